@@ rtl/core/thi_pkg.sv @@
// Shared types and constants for the thermal hold-off integrator.
// No dependencies; every other file in rtl/core except thi_ram imports this package.
`default_nettype none

package thi_pkg;

  localparam int CHANNELS = 4;
  localparam int SENSORS  = 16;
  localparam int ENTRIES  = CHANNELS * SENSORS;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CH_SEL_W = $clog2(CHANNELS);

  localparam int ACC_W   = 40;
  localparam int PROD_W  = 27;  // 14-bit signed delta times 12-bit period
  localparam int HOLD_W  = 32;
  localparam int CNT_W   = 8;
  localparam int LIM_S_W = 30;  // integral limit in seconds
  localparam int HLS_W   = 22;  // hold limit in seconds

  localparam logic [11:0]      PERIOD_RST   = 12'd60;
  localparam logic [HLS_W-1:0] HOLD_SEC_RST = 22'd600;
  localparam logic [CNT_W-1:0] HYST_RST     = 8'd3;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_TICK_PERIOD = 2'd0,
    CFG_HOLD_LIMIT  = 2'd1,
    CFG_HYST_LIMIT  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0]      period;
    logic [HLS_W-1:0] hold_limit_secs;
    logic [CNT_W-1:0] hyst_limit;
  } cfg_t;

  // first pipeline stage contents
  typedef struct packed {
    cmd_t                cmd;
    logic [1:0]          channel;
    logic [3:0]          sensor;
    logic                ch_ok;
    logic                sn_ok;
    logic [CH_SEL_W-1:0] ch_sel;
    logic [IDX_W-1:0]    idx;
    logic [PROD_W-1:0]   prod;
    logic [LIM_S_W-1:0]  limit_secs;
    logic                over_hot;
    logic                last;
  } prep_t;

  typedef struct packed {
    logic [1:0]       channel;
    logic [3:0]       sensor;
    logic [ACC_W-1:0] integral;
    logic             over_hot;
    logic             tick_done;
    logic [CNT_W-1:0] count;
    logic             ready;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/thi_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.
`default_nettype none

module thi_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 40,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/thi_prep.sv @@
// Stage 1: decode, temperature delta times tick period, limit scaling.
// Depends on thi_pkg.
`default_nettype none

module thi_prep
  import thi_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire cmd_t         cmd,
  input  wire logic [1:0]   channel,
  input  wire logic [3:0]   sensor,
  input  wire logic [12:0]  temperature,
  input  wire logic [11:0]  normal_level,
  input  wire logic [11:0]  hot_level,
  input  wire logic [23:0]  integral_limit,
  input  wire logic         last_of_tick,
  input  wire logic [11:0]  period,
  output logic              s1_valid,
  output prep_t             s1
);

  logic signed [13:0]       temp_x;
  logic signed [13:0]       delta;
  logic signed [PROD_W-1:0] prod;
  prep_t                    s1_next;

  always_comb begin
    temp_x = $signed({temperature[12], temperature});
    delta  = temp_x - $signed({2'b00, normal_level});
    prod   = PROD_W'(delta) * PROD_W'($signed({1'b0, period}));

    s1_next.cmd        = cmd;
    s1_next.channel    = channel;
    s1_next.sensor     = sensor;
    s1_next.ch_ok      = 32'(channel) < 32'(CHANNELS);
    s1_next.sn_ok      = 32'(sensor) < 32'(SENSORS);
    s1_next.ch_sel     = CH_SEL_W'(channel);
    s1_next.idx        = IDX_W'(32'(channel) * 32'(SENSORS) + 32'(sensor));
    s1_next.prod       = prod;
    // limit * 60 = limit * 64 - limit * 4
    s1_next.limit_secs = {integral_limit, 6'b0} - {4'b0, integral_limit, 2'b0};
    s1_next.over_hot   = temp_x > $signed({2'b00, hot_level});
    s1_next.last       = last_of_tick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      s1 <= s1_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/thi_update.sv @@
// Stage 2: integral read-modify-write against the integral RAM, entry valid
// bits, write forwarding, and per-channel hold time and hysteresis counter.
// Depends on thi_pkg and thi_ram.
`default_nettype none

module thi_update
  import thi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s1_valid,
  input  wire prep_t s1,
  input  wire logic  adv2,
  input  wire logic  adv_out,
  input  wire cfg_t  cfg,
  output logic       s2_valid,
  output res_t       res
);

  prep_t             s2;
  logic              rd_en;
  logic              commit;
  logic              wr_en;
  logic [ACC_W-1:0]  rdata;
  logic              fwd_hit;
  logic [ACC_W-1:0]  fwd_data;
  logic [ENTRIES-1:0] entry_valid;

  logic [HOLD_W-1:0] hold_secs  [CHANNELS];
  logic [CNT_W-1:0]  cond_cnt   [CHANNELS];
  logic [CHANNELS-1:0] hot_seen;
  logic [CHANNELS-1:0] over_seen;

  logic              is_sample;
  logic              is_clear;
  logic              do_tick;
  logic              period_nz;
  logic [ACC_W-1:0]  base;
  logic [ACC_W:0]    sum;
  logic [ACC_W-1:0]  sat;
  logic [ACC_W-1:0]  acc_new;
  logic              int_over;
  logic [HOLD_W:0]   hold_sum;
  logic [HOLD_W-1:0] hold_new;
  logic              cond;
  logic [CNT_W-1:0]  cnt_cur;
  logic [CNT_W-1:0]  cnt_new;
  logic [CNT_W-1:0]  count;

  assign rd_en  = adv2 && s1_valid;
  assign commit = adv_out && s2_valid;

  thi_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (ACC_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s2.idx),
    .wdata (acc_new),
    .re    (rd_en),
    .raddr (s1.idx),
    .rdata (rdata)
  );

  always_comb begin
    is_sample = s2.ch_ok && (s2.cmd == CMD_SAMPLE) && s2.sn_ok;
    is_clear  = s2.ch_ok && (s2.cmd == CMD_CLEAR);
    do_tick   = s2.ch_ok && (s2.cmd == CMD_SAMPLE) && s2.last;
    period_nz = cfg.period != 12'd0;

    // previous request wrote this entry on the edge our read was issued
    if (fwd_hit) begin
      base = fwd_data;
    end else if (entry_valid[s2.idx]) begin
      base = rdata;
    end else begin
      base = '0;
    end

    sum = {base[ACC_W-1], base} + {{(ACC_W + 1 - PROD_W){s2.prod[PROD_W-1]}}, s2.prod};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sat = sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      sat = sum[ACC_W-1:0];
    end
    acc_new  = period_nz ? sat : base;
    wr_en    = commit && is_sample && period_nz;
    int_over = $signed(acc_new) > $signed({{(ACC_W - LIM_S_W){1'b0}}, s2.limit_secs});

    hold_sum = {1'b0, hold_secs[s2.ch_sel]} + {{(HOLD_W - 11){1'b0}}, cfg.period};
    hold_new = hold_sum[HOLD_W] ? '1 : hold_sum[HOLD_W-1:0];
    cond     = hot_seen[s2.ch_sel] || over_seen[s2.ch_sel]
               || (is_sample && s2.over_hot) || (is_sample && int_over)
               || (hold_new > {{(HOLD_W - HLS_W){1'b0}}, cfg.hold_limit_secs});
    cnt_cur  = cond_cnt[s2.ch_sel];
    if (!cond) begin
      cnt_new = '0;
    end else if (cnt_cur < cfg.hyst_limit) begin
      cnt_new = cnt_cur + CNT_W'(1);
    end else begin
      cnt_new = cnt_cur;
    end

    if (!s2.ch_ok || is_clear) begin
      count = '0;
    end else if (do_tick) begin
      count = cnt_new;
    end else begin
      count = cnt_cur;
    end

    res.channel   = s2.channel;
    res.sensor    = s2.sensor;
    res.integral  = is_sample ? acc_new : '0;
    res.over_hot  = is_sample && s2.over_hot;
    res.tick_done = do_tick;
    res.count     = count;
    res.ready     = s2.ch_ok && (count >= cfg.hyst_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      if (rd_en) begin
        fwd_hit <= wr_en && (s2.idx == s1.idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s2       <= s1;
      fwd_data <= acc_new;
    end
  end

  // entry valid bits stand in for a clearing pass over the RAM
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (commit) begin
      if (wr_en) begin
        entry_valid[s2.idx] <= 1'b1;
      end
      if (is_clear) begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (j / SENSORS == int'(s2.ch_sel)) begin
            entry_valid[j] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        hold_secs[c] <= '0;
        cond_cnt[c]  <= '0;
      end
      hot_seen  <= '0;
      over_seen <= '0;
    end else if (commit) begin
      if (is_clear || do_tick) begin
        hot_seen[s2.ch_sel]  <= 1'b0;
        over_seen[s2.ch_sel] <= 1'b0;
      end else if (is_sample) begin
        if (s2.over_hot) begin
          hot_seen[s2.ch_sel] <= 1'b1;
        end
        if (int_over) begin
          over_seen[s2.ch_sel] <= 1'b1;
        end
      end
      if (is_clear) begin
        hold_secs[s2.ch_sel] <= '0;
        cond_cnt[s2.ch_sel]  <= '0;
      end else if (do_tick) begin
        hold_secs[s2.ch_sel] <= hold_new;
        cond_cnt[s2.ch_sel]  <= cnt_new;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/thermal_holdoff_integrator_unit.sv @@
// Thermal hold-off integrator, top level.
// A request passes the prep register, RAM read with stage-2 register and output
// register. Throughput: one request per cycle while m_tready does not stall the
// output, sustained by the integral RAM read-modify-write with forwarding.
// Reset: synchronous; entry valid bits make all integrals read as zero at
// once, no clearing pass. Depends on thi_pkg, thi_prep, thi_update, thi_ram.
`default_nettype none

module thermal_holdoff_integrator_unit
  import thi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // tdata: channel[1:0] sensor[5:2] temperature[18:6] normal_level[30:19]
  //        hot_level[42:31] integral_limit[66:43], zero fill [71:67]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,
  input  wire logic        s_tuser,   // cmd
  input  wire logic        s_tlast,   // last_of_tick
  // tdata: out_channel[1:0] out_sensor[5:2] integral_value[45:6]
  //        over_hot[46] holdoff_count[54:47] backoff_ready[55]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,
  output logic             m_tlast,   // tick_done
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t  cfg;
  logic  s1_valid;
  prep_t s1;
  logic  s2_valid;
  res_t  res;
  res_t  res_q;
  logic  en_out;
  logic  en2;
  logic  en1;

  assign en_out    = !m_tvalid || m_tready;
  assign en2       = !s2_valid || en_out;
  assign en1       = !s1_valid || en2;
  assign s_tready  = en1;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period          <= PERIOD_RST;
      cfg.hold_limit_secs <= HOLD_SEC_RST;
      cfg.hyst_limit      <= HYST_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TICK_PERIOD: cfg.period <= cfg_data[11:0];
        // minutes * 60 = m * 64 - m * 4
        CFG_HOLD_LIMIT:  cfg.hold_limit_secs <= {cfg_data, 6'b0} - {4'b0, cfg_data, 2'b0};
        CFG_HYST_LIMIT:  cfg.hyst_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  thi_prep u_prep (
    .clk            (clk),
    .rst            (rst),
    .en             (en1),
    .in_valid       (s_tvalid),
    .cmd            (cmd_t'(s_tuser)),
    .channel        (s_tdata[1:0]),
    .sensor         (s_tdata[5:2]),
    .temperature    (s_tdata[18:6]),
    .normal_level   (s_tdata[30:19]),
    .hot_level      (s_tdata[42:31]),
    .integral_limit (s_tdata[66:43]),
    .last_of_tick   (s_tlast),
    .period         (cfg.period),
    .s1_valid       (s1_valid),
    .s1             (s1)
  );

  thi_update u_update (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .adv2     (en2),
    .adv_out  (en_out),
    .cfg      (cfg),
    .s2_valid (s2_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && s2_valid) begin
      res_q <= res;
    end
  end

  assign m_tdata = {res_q.ready, res_q.count, res_q.over_hot, res_q.integral,
                    res_q.sensor, res_q.channel};
  assign m_tlast = res_q.tick_done;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for thermal_holdoff_integrator_unit: streams sensor samples and channel clears,
// predicts every result in a small scoreboard class and compares the fields.
// Depends on thi_pkg and the RTL in rtl/core.
module tb_top;
  import thi_pkg::*;

  localparam int     LATENCY   = 3;
  localparam int     LONG_HOLD = 300;
  localparam int     SAT_STEPS = 8;
  localparam longint ACC_MAX   = 64'sd549755813887;
  localparam longint ACC_MIN   = -ACC_MAX - 1;

  typedef struct {
    cmd_t               cmd;
    logic [1:0]         channel;
    logic [3:0]         sensor;
    logic signed [12:0] temp;
    logic [11:0]        normal;
    logic [11:0]        hot;
    logic [23:0]        limit;
    logic               last;
  } sample_req_t;

  class holdoff_scoreboard;
    logic [11:0] period;
    logic [15:0] hold_min;
    logic [7:0]  hyst;
    longint      integral [CHANNELS*SENSORS];
    logic [31:0] hold_secs [CHANNELS];
    logic [7:0]  cond_cnt [CHANNELS];
    bit          hot_seen [CHANNELS];
    bit          over_seen [CHANNELS];
    res_t        expected_q [$];
    int          errors;
    int          results_seen;

    function new();
      period       = PERIOD_RST;
      hold_min     = 16'd10;
      hyst         = HYST_RST;
      errors       = 0;
      results_seen = 0;
      for (int c = 0; c < CHANNELS; c++) wipe(c);
    endfunction

    function void wipe(int ch);
      for (int s = 0; s < SENSORS; s++) integral[ch*SENSORS + s] = 0;
      hold_secs[ch] = '0;
      cond_cnt[ch]  = '0;
      hot_seen[ch]  = 1'b0;
      over_seen[ch] = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_TICK_PERIOD: period   = val[11:0];
        CFG_HOLD_LIMIT:  hold_min = val;
        CFG_HYST_LIMIT:  hyst     = val[7:0];
        default: ;
      endcase
    endfunction

    function void note_request(sample_req_t r);
      res_t            e;
      int              idx;
      longint          acc;
      longint unsigned h;
      bit              cond;
      e         = '0;
      e.channel = r.channel;
      e.sensor  = r.sensor;
      if (r.cmd == CMD_CLEAR) begin
        wipe(r.channel);
      end else begin
        idx = int'(r.channel) * SENSORS + int'(r.sensor);
        acc = integral[idx];
        // zero period freezes the integral but the flags still see it
        if (period != 0) begin
          acc += (longint'(r.temp) - longint'(r.normal)) * longint'(period);
          if (acc > ACC_MAX) acc = ACC_MAX;
          if (acc < ACC_MIN) acc = ACC_MIN;
          integral[idx] = acc;
        end
        e.integral = acc[39:0];
        e.over_hot = longint'(r.temp) > longint'(r.hot);
        if (e.over_hot) hot_seen[r.channel] = 1'b1;
        if (acc > longint'(r.limit) * 60) over_seen[r.channel] = 1'b1;
        if (r.last) begin
          h = longint'(hold_secs[r.channel]) + longint'(period);
          if (h > 64'hFFFF_FFFF) h = 64'hFFFF_FFFF;
          hold_secs[r.channel] = h[31:0];
          cond = hot_seen[r.channel] || over_seen[r.channel] ||
                 (h > longint'(hold_min) * 60);
          // counter above a lowered limit just holds
          if (!cond) cond_cnt[r.channel] = '0;
          else if (cond_cnt[r.channel] < hyst) cond_cnt[r.channel]++;
          hot_seen[r.channel]  = 1'b0;
          over_seen[r.channel] = 1'b0;
          e.tick_done = 1'b1;
        end
      end
      e.count = cond_cnt[r.channel];
      e.ready = cond_cnt[r.channel] >= hyst;
      expected_q.push_back(e);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("mismatch at result %0d: %s", results_seen, what);
    endtask

    task check_result(res_t got);
      res_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = expected_q.pop_front();
      if (got.channel !== e.channel)
        report($sformatf("channel %0d, want %0d", got.channel, e.channel));
      if (got.sensor !== e.sensor)
        report($sformatf("sensor %0d, want %0d", got.sensor, e.sensor));
      if (got.integral !== e.integral)
        report($sformatf("integral %0d, want %0d",
                         $signed(got.integral), $signed(e.integral)));
      if (got.over_hot !== e.over_hot)
        report($sformatf("over_hot %b, want %b", got.over_hot, e.over_hot));
      if (got.tick_done !== e.tick_done)
        report($sformatf("tick_done %b, want %b", got.tick_done, e.tick_done));
      if (got.count !== e.count)
        report($sformatf("holdoff_count %0d, want %0d", got.count, e.count));
      if (got.ready !== e.ready)
        report($sformatf("backoff_ready %b, want %b", got.ready, e.ready));
    endtask
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  bit gaps_on      = 1'b0;
  bit stalls_on    = 1'b0;
  bit hold_request = 1'b0;
  int requests_sent = 0;

  holdoff_scoreboard sb = new();

  thermal_holdoff_integrator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int   stall;
    res_t got;
    while (rst) @(posedge clk);
    forever begin
      stall = stalls_on ? $urandom_range(0, 5) : 0;
      if (hold_request) begin
        stall        = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.channel   = m_tdata[1:0];
      got.sensor    = m_tdata[5:2];
      got.integral  = m_tdata[45:6];
      got.over_hot  = m_tdata[46];
      got.count     = m_tdata[54:47];
      got.ready     = m_tdata[55];
      got.tick_done = m_tlast;
      sb.check_result(got);
    end
  end

  function automatic sample_req_t make_req(cmd_t cmd, int ch, int sn, int temp, int normal,
                                           int hot, int limit, bit last);
    sample_req_t r;
    r.cmd     = cmd;
    r.channel = 2'(ch);
    r.sensor  = 4'(sn);
    r.temp    = 13'(temp);
    r.normal  = 12'(normal);
    r.hot     = 12'(hot);
    r.limit   = 24'(limit);
    r.last    = last;
    return r;
  endfunction

  function automatic sample_req_t random_sample(logic [1:0] ch, logic last);
    sample_req_t r;
    r.cmd     = CMD_SAMPLE;
    r.channel = ch;
    r.sensor  = 4'($urandom);
    r.last    = last;
    if ($urandom_range(0, 4) == 0) r.temp = 13'($urandom);
    else r.temp = 13'($urandom_range(0, 3100)) - 13'd550;
    r.normal = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(150, 450));
    r.hot    = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(400, 1200));
    r.limit  = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
    return r;
  endfunction

  task automatic send_request(sample_req_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.cmd;
    s_tlast  <= r.last;
    s_tdata  <= {5'b0, r.limit, r.hot, r.normal, r.temp, r.sensor, r.channel};
    do @(posedge clk); while (!s_tready);
    sb.note_request(r);
    requests_sent++;
  endtask

  task automatic load_config(logic [15:0] period, logic [15:0] hold, logic [15:0] hyst);
    cfg_idx_t    regs [3];
    logic [15:0] vals [3];
    regs = '{CFG_TICK_PERIOD, CFG_HOLD_LIMIT, CFG_HYST_LIMIT};
    vals = '{period, hold, hyst};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // ticks: a few samples of one channel closed by last_of_tick, mixed with
  // clears and stray samples
  task automatic run_random(int n);
    int         target;
    int         len;
    logic [1:0] ch;
    sample_req_t r;
    target = requests_sent + n;
    while (requests_sent < target) begin
      if ($urandom_range(0, 15) == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 15) == 0) stalls_on = ($urandom_range(0, 2) != 0);
      ch = 2'($urandom);
      case ($urandom_range(0, 19))
        0: begin
          r     = random_sample(ch, 1'($urandom));
          r.cmd = CMD_CLEAR;
          send_request(r);
        end
        1: send_request(random_sample(ch, 1'($urandom)));
        default: begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) send_request(random_sample(ch, i == len - 1));
        end
      endcase
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  initial begin : stimulus
    int drain;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, at reset configuration
    send_request(make_req(CMD_SAMPLE, 0, 0, 4095, 0, 0, 0, 0));
    send_request(make_req(CMD_SAMPLE, 0, 15, -4096, 4095, 4095, 24'hFFFFFF, 1));
    send_request(make_req(CMD_SAMPLE, 1, 5, 0, 0, 0, 0, 1));
    send_request(make_req(CMD_SAMPLE, 3, 15, 2550, 4095, 2550, 0, 1));
    send_request(make_req(CMD_SAMPLE, 2, 8, -550, 0, 0, 0, 1));
    // counter climbs to the limit, then saturates
    repeat (4) send_request(make_req(CMD_SAMPLE, 0, 0, 4095, 0, 100, 0, 1));
    send_request(make_req(CMD_CLEAR, 0, 3, 1234, 4095, 4095, 24'hFFFFFF, 1));
    send_request(make_req(CMD_SAMPLE, 0, 0, 10, 0, 4095, 0, 1));
    // integral limit: equal is not over, one step later it is
    send_request(make_req(CMD_SAMPLE, 1, 1, 100, 0, 4095, 100, 1));
    send_request(make_req(CMD_SAMPLE, 1, 1, 100, 0, 4095, 199, 1));
    // hold time crosses ten minutes
    repeat (11) send_request(make_req(CMD_SAMPLE, 3, 7, 0, 0, 4095, 24'hFFFFFF, 1));
    settle();

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    load_config(16'h0000, 16'h0000, 16'h0000);
    run_random(120);
    settle();

    // long receiver hold-off while requests keep coming
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(200);
    settle();

    load_config(16'd1, 16'd0, 16'd200);
    run_random(200);
    settle();

    // limit lowered below running counters, conditions keep holding
    load_config(16'd3600, 16'd1, 16'd5);
    run_random(150);
    settle();

    repeat (3) begin
      load_config(16'($urandom_range(0, 3600)), 16'($urandom), 16'($urandom));
      run_random(140);
      settle();
    end

    // largest steps on one integral, up and then well below zero
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    load_config(16'hFFFF, 16'd10, 16'd3);
    send_request(make_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < SAT_STEPS; i++)
      send_request(make_req(CMD_SAMPLE, 0, 0, 4095, 0, 0, 0, 0));
    for (int i = 0; i < SAT_STEPS; i++)
      send_request(make_req(CMD_SAMPLE, 0, 0, -4096, 4095, 0, 0, i == SAT_STEPS - 1));
    send_request(make_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1));
    s_tvalid <= 1'b0;

    drain = 0;
    while (sb.expected_q.size() != 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/thi_pkg.sv
rtl/core/thi_ram.sv
rtl/core/thi_prep.sv
rtl/core/thi_update.sv
rtl/core/thermal_holdoff_integrator_unit.sv
tb/tb_top.sv
